### src/bromap_pkg.sv
// Package for the banked ROM/RAM overlay memory map.
// Holds command codes, address constants and the request structs; no dependencies.
package bromap_pkg;

    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_FETCH = 3'd2;
    localparam logic [2:0] CMD_BANK  = 3'd3;
    localparam logic [2:0] CMD_LOAD  = 3'd4;

    localparam int ROM_BYTES      = 32768;
    localparam int CHAR_RAM_BYTES = 2048;
    localparam int ROM_AW         = $clog2(ROM_BYTES);
    localparam int CHAR_AW        = $clog2(CHAR_RAM_BYTES);

    localparam logic [15:0] WINDOW_BASE = 16'h7800;
    localparam logic [15:0] HIGH_BASE   = 16'h8000;

    typedef enum logic [1:0] {
        SRC_LOW,
        SRC_HIGH,
        SRC_ROM,
        SRC_CHAR
    } src_t;

    // One access to the memory store.
    typedef struct packed {
        logic              rd;
        logic              wr;
        src_t              src;
        logic [ROM_AW-1:0] addr;
        logic [7:0]        wdata;
    } req_t;

    // Side effects of a beat outside the memories.
    typedef struct packed {
        logic has_result;
        logic bank_wr;
        logic fetch;
        logic fetch_in_window;
    } ctl_t;

endpackage

### src/banked_rom_ram_overlay_map_top.sv
// Top level of the banked ROM/RAM overlay memory map.
// Instantiates bromap_decode and bromap_store; uses bromap_pkg.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | input     | in_valid / in_ready   | cmd, address, write_data, select_ram
//   out     | output    | out_valid / out_ready | read_data
//
// One beat per cycle is accepted while in_ready is high; a read or fetch result is
// registered at the memory outputs and then in the output register.
// After reset a clearing sweep zeroes low RAM and character RAM,
// during which in_ready stays low.
// A stalled output holds one result while one more read waits at the memory outputs;
// outside the clearing sweep, in_ready drops only when both are occupied.
module banked_rom_ram_overlay_map_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic        select_ram,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data
);
    import bromap_pkg::*;

    req_t req;
    ctl_t ctl;

    logic       accept;
    logic       clearing;
    logic [7:0] rd_data;
    logic       move;

    logic       low_is_ram_reg;
    logic       code_in_window_reg;
    logic       pend_valid_reg;
    logic       out_valid_reg;
    logic [7:0] read_data_reg;

    bromap_decode u_decode (
        .cmd            (cmd),
        .address        (address),
        .write_data     (write_data),
        .low_is_ram     (low_is_ram_reg),
        .code_in_window (code_in_window_reg),
        .req            (req),
        .ctl            (ctl)
    );

    bromap_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (accept),
        .req       (req),
        .clearing  (clearing),
        .rd_data   (rd_data)
    );

    assign move     = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing && (!pend_valid_reg || !out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_is_ram_reg     <= 1'b0;
            code_in_window_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (ctl.bank_wr)
                low_is_ram_reg <= select_ram;
            if (ctl.fetch)
                code_in_window_reg <= ctl.fetch_in_window;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept && ctl.has_result)
                pend_valid_reg <= 1'b1;
            else if (move)
                pend_valid_reg <= 1'b0;

            if (move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
            read_data_reg <= rd_data;
    end

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("beat accepted during the clearing sweep");

    a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ctl.has_result) |=> pend_valid_reg)
        else $error("read beat did not leave a pending result");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("pending result could be overwritten");

    a_bank_update: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_BANK) |=> (low_is_ram_reg == $past(select_ram)))
        else $error("bank select not taken from the beat");

endmodule

### src/bromap_decode.sv
// Address and command decode of the overlay map.
// Turns one input beat plus the bank and window bits into a store request; uses bromap_pkg.
module bromap_decode (
    input  logic [2:0]         cmd,
    input  logic [15:0]        address,
    input  logic [7:0]         write_data,
    input  logic               low_is_ram,
    input  logic               code_in_window,
    output bromap_pkg::req_t   req,
    output bromap_pkg::ctl_t   ctl
);
    import bromap_pkg::*;

    logic in_high;
    logic in_window;
    src_t code_src;

    assign in_high   = (address >= HIGH_BASE);
    assign in_window = (address >= WINDOW_BASE) && !in_high;

    always_comb
    begin
        priority if (in_high)
            code_src = SRC_HIGH;
        else if (low_is_ram)
            code_src = SRC_LOW;
        else
            code_src = SRC_ROM;
    end

    always_comb
    begin
        req.rd    = 1'b0;
        req.wr    = 1'b0;
        req.src   = code_src;
        req.addr  = address[ROM_AW-1:0];
        req.wdata = write_data;
        ctl       = '0;
        unique case (cmd)
            CMD_READ:
            begin
                req.rd = 1'b1;
                ctl.has_result = 1'b1;
                // Reads in the window see character RAM unless code runs from there or low RAM is selected.
                if (in_window && !low_is_ram && !code_in_window)
                    req.src = SRC_CHAR;
            end
            CMD_WRITE:
            begin
                if (in_high || low_is_ram)
                    req.wr = 1'b1;
                else if (in_window)
                begin
                    req.wr  = 1'b1;
                    req.src = SRC_CHAR;
                end
            end
            CMD_FETCH:
            begin
                req.rd = 1'b1;
                ctl.has_result = 1'b1;
                ctl.fetch = 1'b1;
                ctl.fetch_in_window = in_window;
            end
            CMD_BANK:
                ctl.bank_wr = 1'b1;
            CMD_LOAD:
            begin
                req.wr  = 1'b1;
                req.src = SRC_ROM;
            end
            default:
            begin
                req.rd = 1'b0;
            end
        endcase
    end

endmodule

### src/bromap_store.sv
// Memory store of the overlay map: low RAM, high RAM, ROM and character RAM.
// Synchronous memories with registered reads and a clearing sweep after reset; uses bromap_pkg.
module bromap_store (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  bromap_pkg::req_t req,
    output logic             clearing,
    output logic [7:0]       rd_data
);
    import bromap_pkg::*;

    logic [7:0] low_ram  [ROM_BYTES];
    logic [7:0] high_ram [ROM_BYTES];
    logic [7:0] rom_mem  [ROM_BYTES];
    logic [7:0] chr_mem  [CHAR_RAM_BYTES];

    logic [ROM_AW-1:0] clr_cnt_reg;
    logic [ROM_AW-1:0] clr_cnt_next;
    logic              clearing_reg;
    logic              clearing_next;

    logic [7:0] low_rd_reg;
    logic [7:0] high_rd_reg;
    logic [7:0] rom_rd_reg;
    logic [7:0] char_rd_reg;
    src_t       src_reg;

    logic              low_we;
    logic              char_we;
    logic [ROM_AW-1:0] low_wa;
    logic [7:0]        low_wd;
    logic              rd_go;

    assign clearing = clearing_reg;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg + 1'b1;
        clearing_next = clearing_reg && (clr_cnt_reg != {ROM_AW{1'b1}});
    end

    // Low RAM and character RAM are zeroed together; the character RAM
    // just sees its range swept several times over.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    assign rd_go   = req_valid && req.rd;
    assign low_we  = clearing_reg || (req_valid && req.wr && req.src == SRC_LOW);
    assign char_we = clearing_reg || (req_valid && req.wr && req.src == SRC_CHAR);
    assign low_wa  = clearing_reg ? clr_cnt_reg : req.addr;
    assign low_wd  = clearing_reg ? 8'h00 : req.wdata;

    always_ff @(posedge clk)
    begin
        if (low_we)
            low_ram[low_wa] <= low_wd;
        if (rd_go && req.src == SRC_LOW)
            low_rd_reg <= low_ram[req.addr];
    end

    always_ff @(posedge clk)
    begin
        if (char_we)
            chr_mem[low_wa[CHAR_AW-1:0]] <= low_wd;
        if (rd_go && req.src == SRC_CHAR)
            char_rd_reg <= chr_mem[req.addr[CHAR_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req.wr && req.src == SRC_HIGH)
            high_ram[req.addr] <= req.wdata;
        if (rd_go && req.src == SRC_HIGH)
            high_rd_reg <= high_ram[req.addr];
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req.wr && req.src == SRC_ROM)
            rom_mem[req.addr] <= req.wdata;
        if (rd_go && req.src == SRC_ROM)
            rom_rd_reg <= rom_mem[req.addr];
    end

    always_ff @(posedge clk)
    begin
        if (rd_go)
            src_reg <= req.src;
    end

    always_comb
    begin
        unique case (src_reg)
            SRC_LOW:  rd_data = low_rd_reg;
            SRC_HIGH: rd_data = high_rd_reg;
            SRC_ROM:  rd_data = rom_rd_reg;
            SRC_CHAR: rd_data = char_rd_reg;
            default:  rd_data = low_rd_reg;
        endcase
    end

endmodule

### tb/tb_banked_rom_ram_overlay_map_top.sv
// Testbench for banked_rom_ram_overlay_map_top: directed and random bus accesses
// checked against a behavioral memory map kept here. Depends on bromap_pkg and the RTL.
`timescale 1ns / 100ps

module tb_banked_rom_ram_overlay_map_top;

    import bromap_pkg::*;

    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        select_ram;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;

    // Behavioral copy of the memory map.
    logic [7:0]  low_ram_m  [0:ROM_BYTES-1];
    logic [7:0]  high_ram_m [0:ROM_BYTES-1];
    logic [7:0]  rom_m      [0:ROM_BYTES-1];
    logic [7:0]  char_m     [0:CHAR_RAM_BYTES-1];
    bit          high_written [0:ROM_BYTES-1];
    bit          rom_loaded   [0:ROM_BYTES-1];
    int unsigned high_list[$];
    int unsigned rom_list[$];
    logic        low_is_ram_m;
    logic        code_in_window_m;

    logic [7:0]  expected_bytes[$];
    int          error_count;
    int          beats_sent;
    int          bytes_checked;
    int          bank_switches;
    bit          sender_idles;
    bit          receiver_idles;
    bit          long_hold_req;

    banked_rom_ram_overlay_map_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .address    (address),
        .write_data (write_data),
        .select_ram (select_ram),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Which store a read or fetch at this address sees, given the current bank state.
    function automatic src_t view_source(logic [2:0] op, logic [15:0] addr,
                                         output int unsigned idx);
        if (addr >= HIGH_BASE)
        begin
            idx = 32'(addr - HIGH_BASE);
            return SRC_HIGH;
        end
        idx = 32'(addr[ROM_AW-1:0]);
        if (low_is_ram_m)
            return SRC_LOW;
        if (op == CMD_FETCH || addr < WINDOW_BASE || code_in_window_m)
            return SRC_ROM;
        idx = 32'(addr[CHAR_AW-1:0]);
        return SRC_CHAR;
    endfunction

    function automatic logic [7:0] stored_byte(src_t src, int unsigned idx);
        case (src)
            SRC_LOW:  return low_ram_m[idx];
            SRC_HIGH: return high_ram_m[idx];
            SRC_ROM:  return rom_m[idx];
            default:  return char_m[idx];
        endcase
    endfunction

    // Steers a read or fetch away from high RAM or ROM entries that hold no data yet.
    function automatic logic [15:0] defined_address(logic [2:0] op, logic [15:0] addr);
        int unsigned idx;
        src_t        src;
        if (op != CMD_READ && op != CMD_FETCH)
            return addr;
        src = view_source(op, addr, idx);
        if (src == SRC_HIGH && !high_written[idx])
            return 16'(HIGH_BASE + high_list[$urandom_range(0, high_list.size() - 1)]);
        if (src == SRC_ROM && !rom_loaded[idx])
            return 16'(rom_list[$urandom_range(0, rom_list.size() - 1)]);
        return addr;
    endfunction

    // Applies one accepted beat to the behavioral map and queues any byte it returns.
    task automatic map_access(logic [2:0] op, logic [15:0] addr, logic [7:0] wd,
                              logic sel);
        int unsigned idx;
        src_t        src;
        case (op)
            CMD_READ:
            begin
                src = view_source(op, addr, idx);
                expected_bytes.push_back(stored_byte(src, idx));
            end
            CMD_WRITE:
            begin
                if (addr >= HIGH_BASE)
                begin
                    idx = 32'(addr - HIGH_BASE);
                    high_ram_m[idx] = wd;
                    if (!high_written[idx])
                    begin
                        high_written[idx] = 1'b1;
                        high_list.push_back(idx);
                    end
                end
                else if (low_is_ram_m)
                    low_ram_m[addr[ROM_AW-1:0]] = wd;
                else if (addr >= WINDOW_BASE)
                    char_m[addr[CHAR_AW-1:0]] = wd;
            end
            CMD_FETCH:
            begin
                code_in_window_m = (addr >= WINDOW_BASE && addr < HIGH_BASE);
                src = view_source(op, addr, idx);
                expected_bytes.push_back(stored_byte(src, idx));
            end
            CMD_BANK:
            begin
                low_is_ram_m = sel;
                bank_switches++;
            end
            CMD_LOAD:
            begin
                idx = 32'(addr[ROM_AW-1:0]);
                rom_m[idx] = wd;
                if (!rom_loaded[idx])
                begin
                    rom_loaded[idx] = 1'b1;
                    rom_list.push_back(idx);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Offers one beat and returns at the edge where it is accepted. Valid stays high
    // across back-to-back beats and is lowered only for an idle burst.
    task automatic send_beat(logic [2:0] op, logic [15:0] addr, logic [7:0] wd, logic sel);
        logic [15:0] a;
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        a = defined_address(op, addr);
        in_valid   <= 1'b1;
        cmd        <= op;
        address    <= a;
        write_data <= wd;
        select_ram <= sel;
        do
            @(posedge clk);
        while (!in_ready);
        map_access(op, a, wd, sel);
        beats_sent++;
    endtask

    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 7))
            0:       return 16'h0000 + 16'($urandom_range(0, 15));
            1:       return 16'h77F8 + 16'($urandom_range(0, 15));
            2:       return 16'h7FF0 + 16'($urandom_range(0, 15));
            3:       return 16'h8000 + 16'($urandom_range(0, 15));
            4:       return 16'hFFF0 + 16'($urandom_range(0, 15));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [2:0] pick_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return CMD_READ;
        if (r < 55)
            return CMD_WRITE;
        if (r < 75)
            return CMD_FETCH;
        if (r < 83)
            return CMD_BANK;
        if (r < 95)
            return CMD_LOAD;
        case ($urandom_range(0, 2))
            0:       return CMD_RSVD5;
            1:       return CMD_RSVD6;
            default: return CMD_RSVD7;
        endcase
    endfunction

    task automatic send_random_beats(int count);
        for (int i = 0; i < count; i++)
            send_beat(pick_cmd(), pick_address(), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    // Extremes of every field, each command, and the window cases one by one.
    task automatic test_directed_map();
        send_beat(CMD_LOAD,  16'h0000, 8'hFF, 1'b0);
        send_beat(CMD_LOAD,  16'h7FFF, 8'h81, 1'b0);
        send_beat(CMD_LOAD,  16'h7800, 8'h3C, 1'b0);
        send_beat(CMD_LOAD,  16'h1234, 8'hC3, 1'b0);
        send_beat(CMD_WRITE, 16'h8000, 8'h00, 1'b0);
        send_beat(CMD_WRITE, 16'hFFFF, 8'hFF, 1'b0);
        send_beat(CMD_READ,  16'hFFFF, 8'h00, 1'b0);
        send_beat(CMD_FETCH, 16'h0000, 8'h00, 1'b0);
        // No fetch from the window yet, so the window reads character RAM.
        send_beat(CMD_READ,  16'h7800, 8'h00, 1'b0);
        send_beat(CMD_WRITE, 16'h7800, 8'hA5, 1'b0);
        send_beat(CMD_READ,  16'h7800, 8'h00, 1'b0);
        // A write below the window with ROM selected is dropped.
        send_beat(CMD_WRITE, 16'h1234, 8'h99, 1'b0);
        send_beat(CMD_READ,  16'h1234, 8'h00, 1'b0);
        // Code fetched from the window makes data reads there see ROM.
        send_beat(CMD_FETCH, 16'h7800, 8'h00, 1'b0);
        send_beat(CMD_READ,  16'h7FFF, 8'h00, 1'b0);
        send_beat(CMD_FETCH, 16'h8000, 8'h00, 1'b0);
        send_beat(CMD_READ,  16'h7FFF, 8'h00, 1'b0);
        // RAM in the low half: the window is plain low RAM.
        send_beat(CMD_BANK,  16'h0000, 8'h00, 1'b1);
        send_beat(CMD_READ,  16'h7800, 8'h00, 1'b0);
        send_beat(CMD_WRITE, 16'h1234, 8'h66, 1'b0);
        send_beat(CMD_READ,  16'h1234, 8'h00, 1'b0);
        send_beat(CMD_FETCH, 16'h7FFF, 8'h00, 1'b0);
        send_beat(CMD_BANK,  16'hFFFF, 8'hFF, 1'b0);
        // ROM load offsets wrap to 15 bits.
        send_beat(CMD_LOAD,  16'hF800, 8'h77, 1'b0);
        send_beat(CMD_FETCH, 16'h7800, 8'h00, 1'b0);
        send_beat(CMD_RSVD5, 16'hFFFF, 8'hFF, 1'b1);
        send_beat(CMD_RSVD6, 16'h7800, 8'hFF, 1'b1);
        send_beat(CMD_RSVD7, 16'h8000, 8'hFF, 1'b1);
    endtask

    task automatic test_random_mix();
        send_random_beats(550);
    endtask

    // The receiver stops for a long stretch while reads keep coming, so the
    // block fills up and holds off its input.
    task automatic test_output_backpressure();
        long_hold_req = 1'b1;
        sender_idles  = 1'b0;
        for (int i = 0; i < 24; i++)
            send_beat((i % 3 == 0) ? CMD_FETCH : CMD_READ, pick_address(), 8'h00, 1'b0);
        sender_idles = 1'b1;
    endtask

    task automatic test_full_rate_tail();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        send_random_beats(200);
    endtask

    // Receiver: random short stalls, plus one long hold when asked.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Checks every accepted result beat against the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("read_data beat with nothing expected: actual %02h", read_data);
                error_count++;
            end
            else
            begin
                if (read_data !== expected_bytes[0])
                begin
                    $error("read_data mismatch: expected %02h actual %02h",
                           expected_bytes[0], read_data);
                    error_count++;
                end
                void'(expected_bytes.pop_front());
                bytes_checked++;
            end
        end
    end

    initial
    begin
        #5ms;
        $display("banked_rom_ram_overlay_map_top test failed");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cmd        <= CMD_READ;
        address    <= 16'h0000;
        write_data <= 8'h00;
        select_ram <= 1'b0;
        error_count      = 0;
        beats_sent       = 0;
        bytes_checked    = 0;
        bank_switches    = 0;
        sender_idles     = 1'b1;
        receiver_idles   = 1'b1;
        long_hold_req    = 1'b0;
        low_is_ram_m     = 1'b0;
        code_in_window_m = 1'b0;
        for (int i = 0; i < ROM_BYTES; i++)
        begin
            low_ram_m[i]  = 8'h00;
            high_ram_m[i] = 8'h00;
            rom_m[i]      = 8'h00;
        end
        for (int i = 0; i < CHAR_RAM_BYTES; i++)
            char_m[i] = 8'h00;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_map();
        test_random_mix();
        test_output_backpressure();
        test_full_rate_tail();

        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d beats with %0d bank switches; checked %0d read and fetch bytes.",
                 beats_sent, bank_switches, bytes_checked);
        $display("ROM entries loaded: %0d, high RAM entries written: %0d.",
                 rom_list.size(), high_list.size());
        if (error_count == 0)
            $display("banked_rom_ram_overlay_map_top test passed");
        else
            $display("banked_rom_ram_overlay_map_top test failed");
        $finish;
    end

endmodule

### files.f
src/bromap_pkg.sv
src/bromap_decode.sv
src/bromap_store.sv
src/banked_rom_ram_overlay_map_top.sv
tb/tb_banked_rom_ram_overlay_map_top.sv
